/* sv/grbc_pkg.sv */
// Shared constants and command/status codes for the grid rectangle blocker counter.
// No dependencies.
`timescale 1ns / 1ps
package grbc_pkg;

    localparam int GRID_DIM     = 64;
    localparam int MAX_BLOCKERS = 16;
    localparam int CELLS        = GRID_DIM * GRID_DIM;
    localparam int CELL_AW      = $clog2(CELLS);
    localparam int COORD_W      = 6;
    localparam int SLOT_W       = 4;
    localparam int COUNT_W      = 5;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_UPDATE = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_QUERY  = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RECT  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_HNDL  = 2'd3;

    localparam logic [1:0] REG_GRID_W   = 2'd0;
    localparam logic [1:0] REG_GRID_H   = 2'd1;
    localparam logic [1:0] REG_CAPACITY = 2'd2;

endpackage

/* sv/grid_rect_blocker_counter.sv */
// Occupancy grid with dynamic blocker rectangles: base cell store, cover count
// store, blocker slot pool and a walk sequencer. Depends on grbc_pkg.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction;
//   output channel (out_valid/out_ready) returns exactly one result for it.
//   cfg_valid/cfg_ready writes grid_width (0), grid_height (1) and
//   blocker_capacity (2); write only while the block is idle.
//   Load goes from accept straight to the result; query passes the execute
//   and query states; unknown commands, failed add/update/remove and an
//   update to an identical rectangle pass the execute state only. A walk
//   reads then writes the cover count memory port for each covered cell:
//   add and remove walk their rectangle, a changing update old then new.
//   One command is in flight at a time; in_ready is low until the result has
//   been taken.
//   Reset: after rst_n releases, a clearing pass zeroes the 4096-entry cover
//   count memory, one entry per cycle; in_ready stays low then,
//   configuration writes are taken throughout.
//   Stall: a result is held in the output registers until out_ready.
module grid_rect_blocker_counter
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [6:0]                      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      command,
    input  logic [5:0]                      cell_x,
    input  logic [5:0]                      cell_y,
    input  logic [6:0]                      rect_width,
    input  logic [6:0]                      rect_height,
    input  logic [3:0]                      blocker_slot,
    input  logic [7:0]                      blocker_generation,
    input  logic                            load_blocked,
    input  logic [7:0]                      load_cost,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic                            cell_blocked,
    output logic [4:0]                      cover_count,
    output logic [7:0]                      cell_cost,
    output logic [3:0]                      new_slot,
    output logic [7:0]                      new_generation,
    output logic [63:0]                     revision
);
    import grbc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_QUERY, S_WALK_RD, S_WALK_WR, S_RESP
    } state_t;

    state_t state_reg;

    // configuration
    logic [6:0] gw_reg, gh_reg;
    logic [4:0] cap_reg;
    logic [6:0] eff_w, eff_h;
    logic [4:0] eff_cap;

    // latched command
    logic [2:0] cmd_reg;
    logic [5:0] x_reg, y_reg;
    logic [6:0] w_reg, h_reg;
    logic [7:0] gen_reg;
    logic       ok_reg, found_reg, ingrid_reg;
    logic [SLOT_W-1:0] idx_reg;

    // slot pool
    logic [MAX_BLOCKERS-1:0] slot_valid_reg;
    logic [7:0]  slot_gen_reg [MAX_BLOCKERS];
    logic [25:0] slot_rect_reg [MAX_BLOCKERS];

    // walk control
    logic [5:0] wx0_reg, wxe_reg, wye_reg, cx_reg, cy_reg;
    logic       up_reg, pend_reg;
    logic [CELL_AW-1:0] clr_reg;

    // memories
    logic [COUNT_W-1:0] cov_mem [CELLS];
    logic [8:0]         base_mem [CELLS];
    logic [COUNT_W-1:0] cov_rdata;
    logic [8:0]         base_rdata;
    logic               cov_we, base_we;
    logic [CELL_AW-1:0] cov_waddr, cov_raddr;
    logic [COUNT_W-1:0] cov_wdata;

    // result registers
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic        blk_reg;
    logic [4:0]  cnt_reg;
    logic [7:0]  cost_reg;
    logic [3:0]  nslot_reg;
    logic [7:0]  ngen_reg;
    logic [63:0] rev_reg;

    logic        accept;
    logic        in_ok, in_grid_in;
    logic        alloc_found;
    logic [SLOT_W-1:0] alloc_idx;
    logic [25:0] old_rect;
    logic        handle_ok, same_rect;
    logic [7:0]  gen_inc, gen_new;
    logic [63:0] rev_bump;
    logic [5:0]  new_xe, new_ye, old_xe, old_ye;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept    = in_valid && in_ready;

    assign eff_w   = (gw_reg > 7'(GRID_DIM)) ? 7'(GRID_DIM) : gw_reg;
    assign eff_h   = (gh_reg > 7'(GRID_DIM)) ? 7'(GRID_DIM) : gh_reg;
    assign eff_cap = (cap_reg > 5'(MAX_BLOCKERS)) ? 5'(MAX_BLOCKERS) : cap_reg;

    // check bounds of the incoming cell and rectangle
    assign in_grid_in = ({1'b0, cell_x} < eff_w) && ({1'b0, cell_y} < eff_h);
    assign in_ok = (rect_width != 7'd0) && (rect_height != 7'd0) && in_grid_in
                   && (rect_width <= eff_w - {1'b0, cell_x})
                   && (rect_height <= eff_h - {1'b0, cell_y});

    // find lowest free slot below capacity
    always_comb
    begin
        alloc_found = 1'b0;
        alloc_idx   = '0;
        for (int i = MAX_BLOCKERS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i] && (5'(i) < eff_cap))
            begin
                alloc_found = 1'b1;
                alloc_idx   = SLOT_W'(i);
            end
        end
    end

    // slot entry of the latched handle or allocation
    assign old_rect  = slot_rect_reg[idx_reg];
    assign handle_ok = slot_valid_reg[idx_reg] && (slot_gen_reg[idx_reg] == gen_reg);
    assign same_rect = (old_rect == {x_reg, y_reg, w_reg, h_reg});
    assign gen_inc   = slot_gen_reg[idx_reg] + 8'd1;
    assign gen_new   = (gen_inc == 8'd0) ? 8'd1 : gen_inc;
    assign rev_bump  = (rev_reg == '1) ? 64'd1 : rev_reg + 64'd1;
    assign new_xe    = 6'(7'(x_reg) + w_reg - 7'd1);
    assign new_ye    = 6'(7'(y_reg) + h_reg - 7'd1);
    assign old_xe    = 6'(7'(old_rect[25:20]) + old_rect[13:7] - 7'd1);
    assign old_ye    = 6'(7'(old_rect[19:14]) + old_rect[6:0] - 7'd1);

    // memory port control
    always_comb
    begin
        cov_we    = (state_reg == S_CLEAR) || (state_reg == S_WALK_WR);
        cov_waddr = (state_reg == S_CLEAR) ? clr_reg : {cy_reg, cx_reg};
        cov_raddr = (state_reg == S_EXEC) ? {y_reg, x_reg} : {cy_reg, cx_reg};
        if (state_reg == S_CLEAR)
            cov_wdata = '0;
        else if (up_reg)
            cov_wdata = (cov_rdata == '1) ? cov_rdata : cov_rdata + 5'd1;
        else
            cov_wdata = (cov_rdata == '0) ? cov_rdata : cov_rdata - 5'd1;
        base_we = accept && (command == CMD_LOAD) && in_grid_in;
    end

    // cover count memory
    always_ff @(posedge clk)
    begin
        if (cov_we)
            cov_mem[cov_waddr] <= cov_wdata;
        cov_rdata <= cov_mem[cov_raddr];
    end

    // base cell memory
    always_ff @(posedge clk)
    begin
        if (base_we)
            base_mem[{cell_y, cell_x}] <= {load_blocked, load_cost};
        base_rdata <= base_mem[{y_reg, x_reg}];
    end

    // latched command payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            x_reg      <= cell_x;
            y_reg      <= cell_y;
            w_reg      <= rect_width;
            h_reg      <= rect_height;
            gen_reg    <= blocker_generation;
            ok_reg     <= in_ok;
            ingrid_reg <= in_grid_in;
            found_reg  <= alloc_found;
            idx_reg    <= (command == CMD_ADD) ? alloc_idx : blocker_slot;
        end
    end

    // sequencer, slot pool and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            gw_reg         <= 7'd64;
            gh_reg         <= 7'd64;
            cap_reg        <= 5'd16;
            slot_valid_reg <= '0;
            for (int i = 0; i < MAX_BLOCKERS; i++)
                slot_gen_reg[i] <= '0;
            rev_reg        <= '0;
            out_valid_reg  <= 1'b0;
            up_reg         <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            // take configuration writes at any time
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_GRID_W:   gw_reg  <= cfg_data;
                    REG_GRID_H:   gh_reg  <= cfg_data;
                    REG_CAPACITY: cap_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= ST_OK;
                        blk_reg    <= 1'b0;
                        cnt_reg    <= '0;
                        cost_reg   <= '0;
                        nslot_reg  <= '0;
                        ngen_reg   <= '0;
                        if (command == CMD_LOAD)
                        begin
                            if (!in_grid_in)
                                status_reg <= ST_BAD_RECT;
                            state_reg <= S_RESP;
                        end
                        else
                            state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_RESP;
                    priority case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (!ok_reg)
                                status_reg <= ST_BAD_RECT;
                            else if (!found_reg)
                                status_reg <= ST_FULL;
                            else
                            begin
                                slot_gen_reg[idx_reg]   <= gen_new;
                                slot_valid_reg[idx_reg] <= 1'b1;
                                slot_rect_reg[idx_reg]  <= {x_reg, y_reg, w_reg, h_reg};
                                nslot_reg <= idx_reg;
                                ngen_reg  <= gen_new;
                                rev_reg   <= rev_bump;
                                wx0_reg   <= x_reg;
                                cx_reg    <= x_reg;
                                cy_reg    <= y_reg;
                                wxe_reg   <= new_xe;
                                wye_reg   <= new_ye;
                                up_reg    <= 1'b1;
                                pend_reg  <= 1'b0;
                                state_reg <= S_WALK_RD;
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (!ok_reg)
                                status_reg <= ST_BAD_RECT;
                            else if (!handle_ok)
                                status_reg <= ST_BAD_HNDL;
                            else if (!same_rect)
                            begin
                                slot_rect_reg[idx_reg] <= {x_reg, y_reg, w_reg, h_reg};
                                rev_reg   <= rev_bump;
                                wx0_reg   <= old_rect[25:20];
                                cx_reg    <= old_rect[25:20];
                                cy_reg    <= old_rect[19:14];
                                wxe_reg   <= old_xe;
                                wye_reg   <= old_ye;
                                up_reg    <= 1'b0;
                                pend_reg  <= 1'b1;
                                state_reg <= S_WALK_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!handle_ok)
                                status_reg <= ST_BAD_HNDL;
                            else
                            begin
                                slot_valid_reg[idx_reg] <= 1'b0;
                                rev_reg   <= rev_bump;
                                wx0_reg   <= old_rect[25:20];
                                cx_reg    <= old_rect[25:20];
                                cy_reg    <= old_rect[19:14];
                                wxe_reg   <= old_xe;
                                wye_reg   <= old_ye;
                                up_reg    <= 1'b0;
                                pend_reg  <= 1'b0;
                                state_reg <= S_WALK_RD;
                            end
                        end
                        CMD_QUERY:
                        begin
                            state_reg <= S_QUERY;
                        end
                        default: ;
                    endcase
                end
                S_QUERY:
                begin
                    // out of bounds reads as blocked with zero count and cost
                    if (!ingrid_reg)
                        blk_reg <= 1'b1;
                    else
                    begin
                        blk_reg  <= base_rdata[8] || (cov_rdata != '0);
                        cnt_reg  <= cov_rdata;
                        cost_reg <= base_rdata[7:0];
                    end
                    state_reg <= S_RESP;
                end
                S_WALK_RD:
                begin
                    state_reg <= S_WALK_WR;
                end
                S_WALK_WR:
                begin
                    // advance along the row, then down; chain the new rectangle
                    state_reg <= S_WALK_RD;
                    if (cx_reg != wxe_reg)
                        cx_reg <= cx_reg + 6'd1;
                    else
                    begin
                        cx_reg <= wx0_reg;
                        if (cy_reg != wye_reg)
                            cy_reg <= cy_reg + 6'd1;
                        else if (pend_reg)
                        begin
                            wx0_reg  <= x_reg;
                            cx_reg   <= x_reg;
                            cy_reg   <= y_reg;
                            wxe_reg  <= new_xe;
                            wye_reg  <= new_ye;
                            up_reg   <= 1'b1;
                            pend_reg <= 1'b0;
                        end
                        else
                            state_reg <= S_RESP;
                    end
                end
                S_RESP:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign cell_blocked   = blk_reg;
    assign cover_count    = cnt_reg;
    assign cell_cost      = cost_reg;
    assign new_slot       = nslot_reg;
    assign new_generation = ngen_reg;
    assign revision       = rev_reg;

endmodule
